### src/lvn_pkg.sv
package lvn_pkg;
    localparam int TABLE_BITS = 8;
    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 32;
    localparam int NOISE_W    = 16;
    localparam int GRAIN_W    = 5;
    localparam int ACC_W      = 44;
    localparam logic [GRAIN_W-1:0] GRAIN_RESET = 5'd13;
    localparam logic [GRAIN_W-1:0] GRAIN_MIN   = 5'd1;
    localparam logic [GRAIN_W-1:0] GRAIN_MAX   = 5'd24;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Hash byte to Q15 corner value: round(h * 32768 / 255) - 16384.
    // Since h * 32768 = 255 * 128 * h + 128 * h, only 128 * h + 127 is divided
    // by 255, and for values below 65280 that quotient is (t + (t >> 8) + 1) >> 8.
    function automatic logic signed [NOISE_W:0] corner_val(input logic [7:0] h);
        logic [15:0] t;
        logic [15:0] q;
        logic [15:0] sum;
        begin
            t   = {1'b0, h, 7'd0} + 16'd127;
            q   = (t + {8'd0, t[15:8]} + 16'd1) >> 8;
            sum = {1'b0, h, 7'd0} + {8'd0, q[7:0]};
            corner_val = $signed({1'b0, sum}) - 17'sd16384;
        end
    endfunction
endpackage

### src/lattice_value_noise_3d.sv
// Channel  Dir  Bus                      Contents
// s_axis   in   tdata[111:0], tuser[0]   write or evaluate request
// m_axis   out  tdata[47:0]              noise vector
// apb      in   paddr[0]                 grain_shift at 0
// An evaluate request steps through setup states S_W1 and S_W2, then through the
// states S_CORNER to S_ACC for each of the 8 corners (five chained reads of the
// one table RAM port, weights and accumulate), and then S_OUT, which registers the
// result and returns to S_IDLE, where the next request is taken. A table write is
// done in S_IDLE on acceptance. Reset makes the table the identity at once; no
// clearing pass. The next request is taken while a result waits on the output
// register; an evaluate holds in S_OUT until the waiting result is taken.
module lattice_value_noise_3d (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: table_index[7:0], table_value[15:8], pos_x[47:16], pos_y[79:48], pos_z[111:80]
    input  logic [111:0] s_axis_tdata,
    // tuser: op[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: noise_x[15:0], noise_y[31:16], noise_z[47:32]
    output logic [47:0]  m_axis_tdata
);
    import lvn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_W1, S_W2, S_CORNER, S_RZ, S_RY, S_RX, S_RHY, S_RHZ, S_ACC, S_OUT
    } state_t;

    state_t state_reg;
    logic [GRAIN_W-1:0] grain_reg;
    logic [31:0] cell_reg [3];
    logic [FRAC_BITS:0] fr_reg [3];
    logic [FRAC_BITS:0] fs_reg [3];
    logic [2:0] corner_reg;
    logic [FRAC_BITS:0] w1_reg, w_reg;
    logic [7:0] hx_reg, hy_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic [POS_W-1:0] pos_reg [3];
    logic [47:0] out_reg;
    logic out_valid_reg;
    logic [7:0] rd_addr;
    logic [7:0] rd_data;
    logic wr_en;
    logic [GRAIN_W-1:0] gs;

    assign pready = 1'b1;
    assign prdata = {{(32-GRAIN_W){1'b0}}, grain_reg};
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign wr_en = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_WRITE);
    assign gs = (grain_reg < GRAIN_MIN) ? GRAIN_MIN :
                (grain_reg > GRAIN_MAX) ? GRAIN_MAX : grain_reg;

    lvn_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (s_axis_tdata[7:0]),
        .wr_data (s_axis_tdata[15:8]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (state_reg)
            S_CORNER: rd_addr = cell_reg[2][7:0] + {7'd0, corner_reg[0]};
            S_RZ:     rd_addr = cell_reg[1][7:0] + {7'd0, corner_reg[1]} + rd_data;
            S_RY:     rd_addr = cell_reg[0][7:0] + {7'd0, corner_reg[2]} + rd_data;
            S_RX:     rd_addr = rd_data;
            S_RHY:    rd_addr = rd_data;
            default:  rd_addr = 8'd0;
        endcase
    end

    // Split each axis into cell and fraction.
    logic [63:0] sv [3];
    logic [31:0] cell_n [3];
    logic [FRAC_BITS:0] fr_n [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [63:0] low;
            low = 64'd0;
            sv[k] = {{32{pos_reg[k][31]}}, pos_reg[k]};
            cell_n[k] = 32'(sv[k] >> gs);
            low = sv[k] & ((64'd1 << gs) - 64'd1);
            if (gs >= GRAIN_W'(FRAC_BITS))
                fr_n[k] = (FRAC_BITS+1)'(low >> (gs - GRAIN_W'(FRAC_BITS)));
            else
                fr_n[k] = (FRAC_BITS+1)'(low << (GRAIN_W'(FRAC_BITS) - gs));
        end
    end

    logic [FRAC_BITS:0] wa, wb, wc;
    logic [2*FRAC_BITS+1:0] p1, p2;
    assign wa = corner_reg[2] ? fr_reg[0] : fs_reg[0];
    assign wb = corner_reg[1] ? fr_reg[1] : fs_reg[1];
    assign wc = corner_reg[0] ? fr_reg[2] : fs_reg[2];
    assign p1 = wa * wb + (2*FRAC_BITS+2)'(1 << (FRAC_BITS-1));
    assign p2 = w1_reg * wc + (2*FRAC_BITS+2)'(1 << (FRAC_BITS-1));

    logic signed [ACC_W-1:0] prod [3];
    logic [7:0] hsel [3];
    assign hsel[0] = hx_reg;
    assign hsel[1] = hy_reg;
    assign hsel[2] = rd_data;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            prod[k] = ACC_W'($signed({1'b0, w_reg}) * corner_val(hsel[k]));
    end

    logic [NOISE_W-1:0] fin [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [ACC_W-1:0] r;
            r = (acc_reg[k] + ACC_W'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
            if (r > ACC_W'(16384))
                fin[k] = NOISE_W'(16384);
            else if (r < -ACC_W'(16384))
                fin[k] = NOISE_W'(-16384);
            else
                fin[k] = r[NOISE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            grain_reg     <= GRAIN_RESET;
            out_valid_reg <= 1'b0;
            corner_reg    <= 3'd0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 1'b0)
                grain_reg <= pwdata[GRAIN_W-1:0];
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_EVAL)
                    begin
                        pos_reg[0] <= s_axis_tdata[47:16];
                        pos_reg[1] <= s_axis_tdata[79:48];
                        pos_reg[2] <= s_axis_tdata[111:80];
                        state_reg  <= S_W1;
                    end
                end
                S_W1:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        cell_reg[k] <= cell_n[k];
                        fr_reg[k]   <= fr_n[k];
                        fs_reg[k]   <= (FRAC_BITS+1)'(1 << FRAC_BITS) - fr_n[k];
                        acc_reg[k]  <= '0;
                    end
                    corner_reg <= 3'd0;
                    state_reg  <= S_W2;
                end
                S_W2: state_reg <= S_CORNER;
                S_CORNER:
                begin
                    w1_reg    <= p1[2*FRAC_BITS:FRAC_BITS];
                    state_reg <= S_RZ;
                end
                S_RZ:
                begin
                    w_reg     <= p2[2*FRAC_BITS:FRAC_BITS];
                    state_reg <= S_RY;
                end
                S_RY: state_reg <= S_RX;
                S_RX:
                begin
                    hx_reg    <= rd_data;
                    state_reg <= S_RHY;
                end
                S_RHY:
                begin
                    hy_reg    <= rd_data;
                    state_reg <= S_RHZ;
                end
                S_RHZ:
                begin
                    for (int k = 0; k < 3; k++)
                        acc_reg[k] <= acc_reg[k] + prod[k];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    corner_reg <= corner_reg + 3'd1;
                    state_reg  <= (corner_reg == 3'd7) ? S_OUT : S_CORNER;
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg       <= {fin[2], fin[1], fin[0]};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### src/lvn_table.sv
module lvn_table (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [7:0] wr_addr,
    input  logic [7:0] wr_data,
    input  logic [7:0] rd_addr,
    output logic [7:0] rd_data
);
    // Entries not yet written read as their own index.
    logic [7:0]   mem [0:255];
    logic [255:0] written_reg;
    logic [7:0]   mem_q_reg;
    logic [7:0]   addr_q_reg;
    logic         hit_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg  <= mem[rd_addr];
        addr_q_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_q_reg   <= 1'b0;
        end
        else
        begin
            hit_q_reg <= written_reg[rd_addr];
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = hit_q_reg ? mem_q_reg : addr_q_reg;
endmodule

### tb/lattice_value_noise_3d_test.sv
module lattice_value_noise_3d_test;
    import lvn_pkg::*;

    typedef struct packed {
        logic signed [NOISE_W-1:0] nz;
        logic signed [NOISE_W-1:0] ny;
        logic signed [NOISE_W-1:0] nx;
    } noise_t;

    typedef struct {
        logic        op;
        logic [7:0]  idx;
        logic [7:0]  val;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        bit          typed;
        noise_t      want;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [0:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;

    logic [7:0]         perm_model [256];
    logic [GRAIN_W-1:0] grain_model;
    noise_t             noise_q [$];
    int                 fail_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_left;
    int                 quiet_cycles;

    lattice_value_noise_3d uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint corner_q15(input logic [7:0] h);
        longint num;
        begin
            num = longint'(h) * 32768 + 127;
            return num / 255 - 16384;
        end
    endfunction

    function automatic longint unsigned round_mul(input longint unsigned a,
                                                  input longint unsigned b);
        return (a * b + 64'd32768) >> FRAC_BITS;
    endfunction

    function automatic noise_t eval_noise(input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] pz);
        int unsigned       gs;
        logic [31:0]       pos [3];
        logic [31:0]       cell_idx [3];
        longint unsigned   fr [3];
        longint unsigned   fs [3];
        longint            acc [3];
        longint            v;
        longint unsigned   low;
        longint unsigned   w;
        longint            r;
        logic [7:0]        hx;
        logic [7:0]        hy;
        logic [7:0]        hz;
        logic [7:0]        t;
        int unsigned       dx;
        int unsigned       dy;
        int unsigned       dz;
        noise_t            res;
        begin
            gs = grain_model;
            if (gs < GRAIN_MIN)
                gs = GRAIN_MIN;
            if (gs > GRAIN_MAX)
                gs = GRAIN_MAX;
            pos[0] = px;
            pos[1] = py;
            pos[2] = pz;
            for (int k = 0; k < 3; k++)
            begin
                v = longint'($signed(pos[k]));
                cell_idx[k] = 32'(v >>> gs);
                low = longint'(v) & ((64'd1 << gs) - 1);
                if (gs >= FRAC_BITS)
                    fr[k] = low >> (gs - FRAC_BITS);
                else
                    fr[k] = low << (FRAC_BITS - gs);
                fs[k] = (64'd1 << FRAC_BITS) - fr[k];
                acc[k] = 0;
            end
            for (int c = 0; c < 8; c++)
            begin
                dx = (c >> 2) & 1;
                dy = (c >> 1) & 1;
                dz = c & 1;
                t  = perm_model[8'(cell_idx[2] + dz)];
                t  = perm_model[8'(cell_idx[1] + dy + t)];
                hx = perm_model[8'(cell_idx[0] + dx + t)];
                hy = perm_model[hx];
                hz = perm_model[hy];
                w = round_mul(round_mul(dx ? fr[0] : fs[0], dy ? fr[1] : fs[1]),
                              dz ? fr[2] : fs[2]);
                acc[0] += longint'(w) * corner_q15(hx);
                acc[1] += longint'(w) * corner_q15(hy);
                acc[2] += longint'(w) * corner_q15(hz);
            end
            for (int k = 0; k < 3; k++)
            begin
                r = (acc[k] + 32768) >>> FRAC_BITS;
                if (r > 16384)
                    r = 16384;
                if (r < -16384)
                    r = -16384;
                acc[k] = r;
            end
            res.nx = acc[0][15:0];
            res.ny = acc[1][15:0];
            res.nz = acc[2][15:0];
            return res;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Checks every accepted noise vector against the oldest expectation.
    always @(posedge clk)
    begin
        noise_t got;
        noise_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (noise_q.size() == 0)
            begin
                report_mismatch("unexpected noise results", 1, 0);
            end
            else
            begin
                want = noise_q.pop_front();
                if (got.nx != want.nx)
                    report_mismatch("noise_x", got.nx, want.nx);
                if (got.ny != want.ny)
                    report_mismatch("noise_y", got.ny, want.ny);
                if (got.nz != want.nz)
                    report_mismatch("noise_z", got.nz, want.nz);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_grain(input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 1'b0;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        grain_model = value[GRAIN_W-1:0];
    endtask

    task automatic send_request(input stim_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.op;
        s_axis_tdata  <= {row.pz, row.py, row.px, row.val, row.idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (row.op == OP_WRITE)
            perm_model[row.idx] = row.val;
        else if (row.typed)
            noise_q.push_back(row.want);
        else
            noise_q.push_back(eval_noise(row.px, row.py, row.pz));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (noise_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] random_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8191)) - 4096);
            2: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
            default: return 32'h8000_0000 ^ 32'($urandom_range(3));
        endcase
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        row.op    = ($urandom_range(99) < 20) ? OP_WRITE : OP_EVAL;
        row.idx   = 8'($urandom);
        row.val   = 8'($urandom);
        row.px    = random_pos();
        row.py    = random_pos();
        row.pz    = random_pos();
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic stim_row_t mk(input logic op, input logic [7:0] idx,
                                     input logic [7:0] val, input logic [31:0] px,
                                     input logic [31:0] py, input logic [31:0] pz,
                                     input bit typed, input int wv);
        stim_row_t row;
        row.op    = op;
        row.idx   = idx;
        row.val   = val;
        row.px    = px;
        row.py    = py;
        row.pz    = pz;
        row.typed = typed;
        row.want  = {3{16'(wv)}};
        return row;
    endfunction

    initial
    begin
        stim_row_t   directed [$];
        logic [31:0] grains [8];
        int          idle_pct [4][2];

        fail_count     = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 1'b0;
        pwdata         = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_WRITE;
        m_axis_tready  = 1'b0;
        for (int i = 0; i < 256; i++)
            perm_model[i] = 8'(i);
        grain_model = GRAIN_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // At the origin with the identity table the only weighted corner hashes to 0, the lowest value.
        directed.push_back(mk(OP_EVAL, 0, 0, 0, 0, 0, 1, -16384));
        // Entry 0 set to 255 chains every hash of the origin corner to 255.
        directed.push_back(mk(OP_WRITE, 0, 255, 0, 0, 0, 0, 0));
        directed.push_back(mk(OP_EVAL, 0, 0, 0, 0, 0, 1, 16384));
        directed.push_back(mk(OP_WRITE, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(OP_EVAL, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
        directed.push_back(mk(OP_EVAL, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
        directed.push_back(mk(OP_EVAL, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        directed.push_back(mk(OP_EVAL, 0, 0, 32'h0000_1000, 32'hFFFF_F000, 32'h0000_1FFF, 0, 0));
        directed.push_back(mk(OP_EVAL, 0, 0, 32'hFFFF_E000, 32'h0000_2000, 32'h0000_0FFF, 0, 0));
        directed.push_back(mk(OP_WRITE, 255, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(OP_WRITE, 128, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        directed.push_back(mk(OP_EVAL, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 0, 0));
        directed.push_back(mk(OP_EVAL, 8'hFF, 8'hFF, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 0, 0));
        foreach (directed[i])
            send_request(directed[i]);
        drain_results();

        // Grain out of range on both sides; the array also holds the extremes of the legal range for later phases.
        grains = '{32'd0, 32'd31, 32'd1, 32'd24, 32'd16, 32'd8, 32'd20, 32'd13};
        write_grain(grains[0]);
        for (int i = 0; i < 6; i++)
            send_request(mk(OP_EVAL, 0, 0, 32'h7FFF_FFFF - i, 32'h8000_0000 + i, 32'd3 * i, 0, 0));
        drain_results();
        write_grain(grains[1]);
        for (int i = 0; i < 6; i++)
            send_request(mk(OP_EVAL, 0, 0, 32'hFFFF_FFFF - i, 32'h8000_0000 + i, 32'hFF_FFFF, 0, 0));
        drain_results();

        // Receiver holds off long enough for the block to fill and stall its input.
        hold_left = 600;
        for (int i = 0; i < 30; i++)
            send_request(random_row());
        drain_results();

        idle_pct = '{'{0, 0}, '{83, 0}, '{0, 83}, '{26, 26}};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_grain((ph == 7) ? 32'($urandom_range(31)) : grains[ph]);
            send_idle_pct  = idle_pct[ph % 4][0];
            recv_stall_pct = idle_pct[ph % 4][1];
            for (int i = 0; i < 250; i++)
                send_request(random_row());
            drain_results();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### lattice_value_noise_3d.f
src/lvn_pkg.sv
src/lvn_table.sv
src/lattice_value_noise_3d.sv
tb/lattice_value_noise_3d_test.sv
